FILE: hdl/bbrs_pkg.sv
// Shared types and constants for the buffer-based bitrate selector.
package bbrs_pkg;

   localparam int LADDER_ENTRIES = 8;
   localparam int LADDER_IDX_W   = (LADDER_ENTRIES > 1) ? $clog2(LADDER_ENTRIES) : 1;
   localparam int LADDER_CNT_W   = $clog2(LADDER_ENTRIES + 1);

   // request action codes
   localparam logic [1:0] ACT_BUFFER   = 2'd0;
   localparam logic [1:0] ACT_DOWNLOAD = 2'd1;
   localparam logic [1:0] ACT_WRITE    = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_LOW_THR  = 3'd0;
   localparam logic [2:0] CSR_HIGH_THR = 3'd1;
   localparam logic [2:0] CSR_MIN_RATE = 3'd2;
   localparam logic [2:0] CSR_MAX_RATE = 3'd3;
   localparam logic [2:0] CSR_STARTUP  = 3'd4;
   localparam logic [2:0] CSR_PENALTY  = 3'd5;
   localparam logic [2:0] CSR_LADDER_N = 3'd6;
   localparam logic [2:0] CSR_INIT_TPT = 3'd7;

   localparam logic [19:0] RST_LOW_THR  = 20'd10000;
   localparam logic [19:0] RST_HIGH_THR = 20'd45000;
   localparam logic [19:0] RST_MIN_RATE = 20'd100;
   localparam logic [19:0] RST_MAX_RATE = 20'd20000;
   localparam logic [19:0] RST_STARTUP  = 20'd3000;
   localparam logic [19:0] RST_PENALTY  = 20'd5000;

   // bytes * 8e6 * 256 -> Q24.8 kbps numerator
   localparam logic [30:0] SAMPLE_SCALE = 31'd2048000000;
   localparam logic [7:0]  EST_KEEP     = 8'd179;
   localparam logic [7:0]  EST_GAIN     = 8'd77;
   // floor(x/5) = (x * RECIP5) >> 34 for 32-bit x
   localparam logic [31:0] RECIP5       = 32'hCCCCCCCD;

   localparam int DIV_STEPS = 63;
   localparam int DIV_CNT_W = 6;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_D_MUL  = 11'b00000000010,
      ST_D_DIV  = 11'b00000000100,
      ST_D_MIX  = 11'b00000001000,
      ST_B_PREP = 11'b00000010000,
      ST_B_DIV  = 11'b00000100000,
      ST_B_FIN  = 11'b00001000000,
      ST_B_CAPM = 11'b00010000000,
      ST_B_CAP  = 11'b00100000000,
      ST_B_SCAN = 11'b01000000000,
      ST_B_RSP  = 11'b10000000000
   } bbrs_state_type;

   typedef struct packed {
      logic capture;
      logic div_load_dl;
      logic buf_prep;
      logic div_step;
      logic mix;
      logic tgt_fin;
      logic cap_mul;
      logic cap_min;
      logic scan_step;
      logic commit;
   } bbrs_cmd_type;

   typedef struct packed {
      logic dur_zero;
      logic tgt_clamped;
      logic div_last;
      logic scan_done;
      logic rsp_busy;
   } bbrs_sts_type;

endpackage

FILE: hdl/bbrs_ctrl.sv
// Sequencer for the bitrate selector: decodes requests and steps the datapath.
module bbrs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  bbrs_pkg::bbrs_sts_type sts,
   output bbrs_pkg::bbrs_cmd_type cmd
);
   import bbrs_pkg::*;

   bbrs_state_type state_ff, state_in;
   logic           accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (req_action == ACT_BUFFER) state_in = ST_B_PREP;
               else if (req_action == ACT_DOWNLOAD && !sts.dur_zero) state_in = ST_D_MUL;
            end
         end
         ST_D_MUL: begin
            cmd.div_load_dl = 1'b1;
            state_in        = ST_D_DIV;
         end
         ST_D_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_D_MIX;
         end
         ST_D_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_B_PREP: begin
            cmd.buf_prep = 1'b1;
            state_in     = sts.tgt_clamped ? ST_B_CAPM : ST_B_DIV;
         end
         ST_B_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_B_FIN;
         end
         ST_B_FIN: begin
            cmd.tgt_fin = 1'b1;
            state_in    = ST_B_CAPM;
         end
         ST_B_CAPM: begin
            cmd.cap_mul = 1'b1;
            state_in    = ST_B_CAP;
         end
         ST_B_CAP: begin
            cmd.cap_min = 1'b1;
            state_in    = ST_B_SCAN;
         end
         ST_B_SCAN: begin
            if (sts.scan_done) state_in = ST_B_RSP;
            else cmd.scan_step = 1'b1;
         end
         ST_B_RSP: begin
            if (!sts.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

FILE: hdl/bbrs_dp.sv
// Datapath: registers, ladder table, shared divider, estimate and selection logic.
module bbrs_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  bbrs_pkg::bbrs_cmd_type cmd,
   output bbrs_pkg::bbrs_sts_type sts,
   input  logic [1:0]             req_action,
   input  logic [19:0]            req_buffer_level_ms,
   input  logic [31:0]            req_byte_count,
   input  logic [39:0]            req_duration_ns,
   input  logic [2:0]             req_entry_index,
   input  logic [19:0]            req_entry_rate_kbps,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [19:0]            rsp_selected_rate_kbps,
   output logic                   rsp_rate_changed,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_index,
   input  logic [19:0]            csr_wdata
);
   import bbrs_pkg::*;

   // configuration
   logic [19:0] low_ff, high_ff, rmin_ff, rmax_ff, startup_ff, penalty_ff;
   logic [3:0]  lcount_ff;

   logic [19:0] ladder_ff [LADDER_ENTRIES];

   logic [19:0] lvl_ff, lvl_in;
   logic [31:0] bytes_ff;
   logic [39:0] dur_ff;
   logic [62:0] dvd_ff, dvd_in;
   logic [39:0] rem_ff, rem_in;
   logic [39:0] dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [19:0] tgt_ff, tgt_in;
   logic [57:0] capp_ff;
   logic [19:0] best_ff, best_in;
   logic        found_ff, found_in;
   logic [LADDER_CNT_W-1:0] scan_ff, scan_in;
   logic [31:0] est_ff, est_in;
   logic [19:0] cur_ff, cur_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [19:0] rsp_rate_ff, rsp_rate_in;
   logic        rsp_chg_ff, rsp_chg_in;

   logic [20:0] span;
   logic [19:0] span_mag, lv_off, den, q20, rd, sel;
   logic [39:0] prod_b;
   logic [40:0] trial, trial_sub;
   logic        trial_ge;
   logic [31:0] sample;
   logic [39:0] mix;
   logic [23:0] cap;
   logic [LADDER_CNT_W-1:0] count;
   logic        le_lo, ge_hi, corr, wr_ok;
   logic [LADDER_IDX_W-1:0] wr_idx;

   // startup penalty applied on capture
   always_comb begin
      if (req_buffer_level_ms < startup_ff)
         lvl_in = (req_buffer_level_ms > penalty_ff) ? req_buffer_level_ms - penalty_ff : '0;
      else
         lvl_in = req_buffer_level_ms;
   end

   assign le_lo    = lvl_ff <= low_ff;
   assign ge_hi    = lvl_ff >= high_ff;
   assign span     = {1'b0, rmax_ff} - {1'b0, rmin_ff};
   assign span_mag = span[20] ? 20'((~span) + 21'd1) : span[19:0];
   assign lv_off   = lvl_ff - low_ff;
   assign den      = high_ff - low_ff;
   assign prod_b   = 40'(lv_off) * 40'(span_mag);

   assign trial     = {rem_ff, dvd_ff[62]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign trial_ge  = trial >= {1'b0, dvs_ff};

   assign sample = (|dvd_ff[62:32]) ? '1 : dvd_ff[31:0];
   assign mix    = 40'(est_ff) * 40'(EST_KEEP) + 40'(sample) * 40'(EST_GAIN);

   // negative slope: floor = -ceil(|num|/den)
   assign q20  = dvd_ff[19:0];
   assign corr = neg_ff && (rem_ff != '0);

   assign cap = capp_ff[57:34];

   assign count = (32'(lcount_ff) > LADDER_ENTRIES) ? LADDER_CNT_W'(LADDER_ENTRIES)
                                                     : LADDER_CNT_W'(lcount_ff);
   assign rd    = ladder_ff[scan_ff[LADDER_IDX_W-1:0]];
   assign sel   = (count == '0) ? tgt_ff : (found_ff ? best_ff : ladder_ff[0]);

   assign wr_idx = LADDER_IDX_W'(req_entry_index);
   assign wr_ok  = cmd.capture && (req_action == ACT_WRITE) &&
                   (32'(req_entry_index) < LADDER_ENTRIES);

   always_comb begin
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      tgt_in       = tgt_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      scan_in      = scan_ff;
      est_in       = est_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_chg_in   = rsp_chg_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      if (cmd.div_load_dl) begin
         dvd_in = 63'(bytes_ff) * 63'(SAMPLE_SCALE);
         dvs_in = dur_ff;
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.buf_prep) begin
         if (le_lo) tgt_in = rmin_ff;
         else if (ge_hi) tgt_in = rmax_ff;
         else begin
            dvd_in = 63'(prod_b);
            dvs_in = 40'(den);
            rem_in = '0;
            cnt_in = '0;
            neg_in = span[20];
         end
      end
      if (cmd.div_step) begin
         rem_in = trial_ge ? trial_sub[39:0] : trial[39:0];
         dvd_in = {dvd_ff[61:0], trial_ge};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.mix) est_in = mix[39:8];
      if (cmd.tgt_fin)
         tgt_in = neg_ff ? rmin_ff - q20 - 20'(corr) : rmin_ff + q20;
      if (cmd.cap_min) begin
         if ({4'b0, tgt_ff} > cap) tgt_in = cap[19:0];
         scan_in  = '0;
         found_in = 1'b0;
      end
      if (cmd.scan_step) begin
         if (rd <= tgt_ff && (!found_ff || rd > best_ff)) begin
            best_in  = rd;
            found_in = 1'b1;
         end
         scan_in = scan_ff + 1'b1;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_rate_in  = sel;
         rsp_chg_in   = sel != cur_ff;
         cur_in       = sel;
      end
      if (csr_wr_en && csr_index == CSR_INIT_TPT) est_in = {4'b0, csr_wdata, 8'b0};
   end

   assign sts.dur_zero    = req_duration_ns == '0;
   assign sts.tgt_clamped = le_lo || ge_hi;
   assign sts.div_last    = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);
   assign sts.scan_done   = scan_ff == count;
   assign sts.rsp_busy    = rsp_valid_ff && !rsp_ready;

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_selected_rate_kbps = rsp_rate_ff;
   assign rsp_rate_changed       = rsp_chg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff     <= RST_LOW_THR;
         high_ff    <= RST_HIGH_THR;
         rmin_ff    <= RST_MIN_RATE;
         rmax_ff    <= RST_MAX_RATE;
         startup_ff <= RST_STARTUP;
         penalty_ff <= RST_PENALTY;
         lcount_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LOW_THR:  low_ff     <= csr_wdata;
            CSR_HIGH_THR: high_ff    <= csr_wdata;
            CSR_MIN_RATE: rmin_ff    <= csr_wdata;
            CSR_MAX_RATE: rmax_ff    <= csr_wdata;
            CSR_STARTUP:  startup_ff <= csr_wdata;
            CSR_PENALTY:  penalty_ff <= csr_wdata;
            CSR_LADDER_N: lcount_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
      end else begin
         est_ff       <= est_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         scan_ff      <= scan_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lvl_ff   <= lvl_in;
         bytes_ff <= req_byte_count;
         dur_ff   <= req_duration_ns;
      end
      if (wr_ok) ladder_ff[wr_idx] <= req_entry_rate_kbps;
      if (cmd.cap_mul) capp_ff <= 58'(est_ff[31:6]) * 58'(RECIP5);
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      tgt_ff      <= tgt_in;
      best_ff     <= best_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_chg_ff  <= rsp_chg_in;
   end

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("response raised without commit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("commit over a stalled response");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> scan_ff < count)
      else $error("ladder scan past count");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> 32'(cnt_ff) < DIV_STEPS)
      else $error("divider overran its step count");

endmodule

FILE: hdl/buffer_based_bitrate_select.sv
// Buffer-based bitrate selector. One request is worked on at a time; req_ready is
// high only while the block is idle. A ladder write or ignored request is done on capture.
// A download report steps through capture, product, 63 divider steps and estimate
// update. A buffer report skips the division when the level is outside the
// thresholds, then caps the target, scans the ladder entries and waits for any
// previous response to be taken. The 63-step restoring divider is shared by the
// throughput sample and the level interpolation. The response sits in an output
// register, so a new request is taken while it waits.
module buffer_based_bitrate_select (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [19:0] req_buffer_level_ms,
   input  logic [31:0] req_byte_count,
   input  logic [39:0] req_duration_ns,
   input  logic [2:0]  req_entry_index,
   input  logic [19:0] req_entry_rate_kbps,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [19:0] rsp_selected_rate_kbps,
   output logic        rsp_rate_changed,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   import bbrs_pkg::*;

   bbrs_cmd_type cmd;
   bbrs_sts_type sts;

   bbrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .sts        (sts),
      .cmd        (cmd)
   );

   bbrs_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_action             (req_action),
      .req_buffer_level_ms    (req_buffer_level_ms),
      .req_byte_count         (req_byte_count),
      .req_duration_ns        (req_duration_ns),
      .req_entry_index        (req_entry_index),
      .req_entry_rate_kbps    (req_entry_rate_kbps),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_selected_rate_kbps (rsp_selected_rate_kbps),
      .rsp_rate_changed       (rsp_rate_changed),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

endmodule
